[design/ssd_pkg.sv]
// Shared constants, types and sequencer states of the size distributor.
// No dependencies; imported by ssd_div, the core and the testbench.
package ssd_pkg;

  localparam int MAX_MEMBERS = 32;
  localparam int IDX_W       = $clog2(MAX_MEMBERS);
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int IDEAL_W     = 16;
  localparam int WGT_W       = 10;
  localparam int AVAIL_W     = 16;
  localparam int OSIZE_W     = 16;
  localparam int TID_W       = IDEAL_W + CNT_W;
  localparam int WSUM_W      = WGT_W + CNT_W;
  localparam int SIZE_W      = TID_W + 2;
  localparam int WIDE_W      = SIZE_W + WGT_W + 1;
  localparam int MEM_W       = IDEAL_W + 2 * WGT_W;
  localparam int DIV_CNT_W   = $clog2(WIDE_W + 1);

  typedef struct packed {
    logic [IDEAL_W-1:0] ideal;
    logic [WGT_W-1:0]   stretch;
    logic [WGT_W-1:0]   shrink;
  } member_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] dividend;
    logic [WSUM_W-1:0]        divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_SUM,
    ST_SETUP,
    ST_PART_RD,
    ST_PART_MUL,
    ST_PART_GO,
    ST_PART_WAIT,
    ST_REM_SETUP,
    ST_REM_GO,
    ST_REM_WAIT,
    ST_REM_RD,
    ST_REM_UPD,
    ST_CHECK,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_t;

endpackage

[design/ssd_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ssd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/ssd_div.sv]
// Radix-2 restoring signed divider, quotient truncated toward zero.
// Divisor zero gives zero. Depends on ssd_pkg.
module ssd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssd_pkg::div_req_t                 req,
  output logic                              done,
  output logic signed [ssd_pkg::WIDE_W-1:0] quot
);
  import ssd_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WIDE_W-1:0]    mag_r;
  logic [WSUM_W-1:0]    rem_r;
  logic [WSUM_W-1:0]    dvs_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [WSUM_W:0]      trial;
  logic                 ge;

  assign trial = {rem_r, mag_r[WIDE_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(WIDE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r  <= req.dividend[WIDE_W-1];
      mag_r  <= req.dividend[WIDE_W-1] ? WIDE_W'(-req.dividend) : WIDE_W'(req.dividend);
      dvs_r  <= req.divisor;
      zero_r <= req.divisor == '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? WSUM_W'(trial - {1'b0, dvs_r}) : trial[WSUM_W-1:0];
      mag_r <= {mag_r[WIDE_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : (neg_r ? -$signed(mag_r) : $signed(mag_r));

endmodule

[design/stretch_shrink_size_distributor_core.sv]
// Top level of the stretch/shrink size distributor: sequencer and datapath.
// Depends on ssd_pkg, ssd_ram and ssd_div.
//
// Usage: members arrive on the in_ channel, one transaction each (ideal size,
// stretch and shrink weight). The transaction with in_last_member set closes
// the group and carries in_available_size. Beyond MAX_MEMBERS members, member
// data is dropped; the last flag still closes the group.
// Members are accepted in ST_LOAD, where in_stall is low. After the last
// member, in_stall stays high while the block computes and emits. Each pass
// scans the member memory, computes one share per member through the serial
// divider, hands out the remainder (one division, then a read and an update
// per visited member) and checks for negative sizes. Up to n passes run.
// The divider sets the pass length. Results leave on the out_ channel in
// load order, one per member, the last one flagged by out_last_size; each
// passes ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_HOLD, where it holds steady
// while the receiver keeps out_stall high.
// Reset (rst_n low, synchronous) empties the group and drops any output.
module stretch_shrink_size_distributor_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ssd_pkg::IDEAL_W-1:0]         in_member_ideal,
  input  logic [ssd_pkg::WGT_W-1:0]           in_member_stretch,
  input  logic [ssd_pkg::WGT_W-1:0]           in_member_shrink,
  input  logic signed [ssd_pkg::AVAIL_W-1:0]  in_available_size,
  input  logic                                in_last_member,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ssd_pkg::OSIZE_W-1:0]         out_member_size,
  output logic                                out_was_clamped,
  output logic                                out_last_size
);
  import ssd_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r, n_r, passes_r, idx_r;
  logic                      rvld_r;
  logic [IDX_W-1:0]          ridx_r, jr_r;
  logic signed [AVAIL_W-1:0] avail_r;
  logic [TID_W-1:0]          tid_r;
  logic [WSUM_W-1:0]         tst_r, tsh_r;
  logic [CNT_W-1:0]          npos_r, tup_r, tdn_r, ispos_r;
  logic signed [SIZE_W-1:0]  grow_r, done_r, per_r;
  logic signed [WIDE_W-1:0]  dvd_r;
  logic [WSUM_W-1:0]         dvs_r;
  logic [IDEAL_W-1:0]        cur_id_r;
  logic                      up_r, all_r, neg_r, zero_r;
  logic                      out_valid_r, out_clamp_r, out_last_r;
  logic [OSIZE_W-1:0]        out_size_r;

  logic                      mem_we, mem_re, size_we, size_re;
  logic [IDX_W-1:0]          mem_waddr, mem_raddr, size_waddr, size_raddr;
  member_t                   mem_wdata, mrd;
  logic [MEM_W-1:0]          mem_rdata;
  logic [SIZE_W-1:0]         size_wdata, size_rdata;
  logic signed [SIZE_W-1:0]  srd;

  div_req_t                  dreq;
  logic                      div_done;
  logic signed [WIDE_W-1:0]  quot;

  logic                      in_acc, out_acc, room;
  logic signed [SIZE_W-1:0]  grow_c, g_c, d_c, tk_s, rem_c, amt0, amt, d_new;
  logic [CNT_W-1:0]          tk_c;
  logic                      sel_c, scan_end, last_c;
  logic [IDX_W-1:0]          j_c;
  logic signed [WIDE_W-1:0]  grow_w, prod_st, prod_sh;

  ssd_ram #(.W(MEM_W), .DEPTH(MAX_MEMBERS)) u_member_ram (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
    .rd_en(mem_re), .rd_addr(mem_raddr), .rd_data(mem_rdata)
  );

  ssd_ram #(.W(SIZE_W), .DEPTH(MAX_MEMBERS)) u_size_ram (
    .clk(clk), .wr_en(size_we), .wr_addr(size_waddr), .wr_data(size_wdata),
    .rd_en(size_re), .rd_addr(size_raddr), .rd_data(size_rdata)
  );

  ssd_div u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .quot(quot)
  );

  assign mrd      = member_t'(mem_rdata);
  assign srd      = $signed(size_rdata);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign room     = cnt_r < CNT_W'(MAX_MEMBERS);
  assign scan_end = (idx_r == n_r) && !rvld_r;
  assign last_c   = (idx_r + CNT_W'(1)) == n_r;

  assign grow_c  = SIZE_W'(avail_r) - $signed({{(SIZE_W-TID_W){1'b0}}, tid_r});
  assign grow_w  = WIDE_W'(grow_r);
  assign prod_st = grow_w * $signed({{(WIDE_W-WGT_W){1'b0}}, mrd.stretch});
  assign prod_sh = grow_w * $signed({{(WIDE_W-WGT_W){1'b0}}, mrd.shrink});

  assign g_c  = grow_r[SIZE_W-1] ? -grow_r : grow_r;
  assign d_c  = grow_r[SIZE_W-1] ? -done_r : done_r;
  assign tk_c = ((!grow_r[SIZE_W-1] ? tup_r : tdn_r) != '0) ?
                (!grow_r[SIZE_W-1] ? tup_r : tdn_r) : ispos_r;
  assign tk_s = $signed({{(SIZE_W-CNT_W){1'b0}}, tk_c});

  assign j_c   = idx_r[0] ? idx_r[IDX_W-1:0] : IDX_W'(n_r - CNT_W'(1) - idx_r);
  assign sel_c = all_r || ((up_r ? mrd.stretch : mrd.shrink) != '0);
  assign rem_c = grow_r - done_r;
  assign amt0  = (rem_c < per_r) ? rem_c : per_r;
  assign amt   = (!up_r && (amt0 > srd)) ? srd : amt0;
  assign d_new = sel_c ? done_r + amt : done_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_acc && in_last_member) state_nxt = ST_START;
      ST_START:     state_nxt = (avail_r <= 0) ? ST_EMIT_RD : ST_SUM;
      ST_SUM:       if (scan_end) state_nxt = ST_SETUP;
      ST_SETUP:     state_nxt = ST_PART_RD;
      ST_PART_RD:   state_nxt = ST_PART_MUL;
      ST_PART_MUL:  state_nxt = ST_PART_GO;
      ST_PART_GO:   state_nxt = ST_PART_WAIT;
      ST_PART_WAIT: if (div_done) state_nxt = last_c ? ST_REM_SETUP : ST_PART_RD;
      ST_REM_SETUP: state_nxt = (grow_r == done_r) ? ST_CHECK : ST_REM_GO;
      ST_REM_GO:    state_nxt = ST_REM_WAIT;
      ST_REM_WAIT:  if (div_done) state_nxt = (done_r < grow_r) ? ST_REM_RD : ST_CHECK;
      ST_REM_RD:    state_nxt = ST_REM_UPD;
      ST_REM_UPD:   state_nxt = (!last_c && (d_new < grow_r)) ? ST_REM_RD : ST_CHECK;
      ST_CHECK:     if (scan_end) state_nxt = ST_PASS_END;
      ST_PASS_END:  state_nxt = (neg_r && (passes_r != CNT_W'(1))) ? ST_SUM : ST_EMIT_RD;
      ST_EMIT_RD:   state_nxt = ST_EMIT_LD;
      ST_EMIT_LD:   state_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: if (out_acc) state_nxt = last_c ? ST_LOAD : ST_EMIT_RD;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // memory, divider and handshake controls
  always_comb begin
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = cnt_r[IDX_W-1:0];
    mem_wdata  = '{ideal: in_member_ideal, stretch: in_member_stretch,
                   shrink: in_member_shrink};
    mem_re     = 1'b0;
    mem_raddr  = idx_r[IDX_W-1:0];
    size_we    = 1'b0;
    size_waddr = idx_r[IDX_W-1:0];
    size_wdata = SIZE_W'($signed({{(SIZE_W-IDEAL_W){1'b0}}, cur_id_r}) + SIZE_W'(quot));
    size_re    = 1'b0;
    size_raddr = idx_r[IDX_W-1:0];
    dreq       = '{start: 1'b0, dividend: dvd_r, divisor: dvs_r};
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        mem_we   = in_valid && room;
      end
      ST_SUM: begin
        mem_re = idx_r < n_r;
      end
      ST_PART_RD: begin
        mem_re = 1'b1;
      end
      ST_PART_GO, ST_REM_GO: begin
        dreq.start = 1'b1;
      end
      ST_PART_WAIT: begin
        size_we = div_done;
      end
      ST_REM_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = j_c;
        size_re    = 1'b1;
        size_raddr = j_c;
      end
      ST_REM_UPD: begin
        size_we    = sel_c;
        size_waddr = jr_r;
        size_wdata = up_r ? srd + amt : srd - amt;
      end
      ST_CHECK: begin
        mem_re    = idx_r < n_r;
        size_re   = idx_r < n_r;
        mem_we    = rvld_r && srd[SIZE_W-1];
        mem_waddr = ridx_r;
        mem_wdata = '{ideal: '0, stretch: mrd.stretch, shrink: '0};
      end
      ST_EMIT_RD: begin
        size_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD && in_acc && room) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (state_r == ST_EMIT_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
        if (last_c) begin
          cnt_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rvld_r <= 1'b0;
    ridx_r <= idx_r[IDX_W-1:0];
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_last_member) begin
          n_r     <= cnt_r + CNT_W'(room);
          avail_r <= in_available_size;
        end
      end
      ST_START, ST_PASS_END: begin
        if (state_r == ST_START) begin
          zero_r   <= avail_r <= 0;
          passes_r <= n_r;
        end else begin
          passes_r <= passes_r - CNT_W'(1);
        end
        idx_r  <= '0;
        tid_r  <= '0;
        tst_r  <= '0;
        tsh_r  <= '0;
        npos_r <= '0;
        tup_r  <= '0;
        tdn_r  <= '0;
      end
      ST_SUM: begin
        if (idx_r < n_r) begin
          idx_r  <= idx_r + CNT_W'(1);
          rvld_r <= 1'b1;
        end
        if (rvld_r) begin
          tid_r  <= tid_r + TID_W'(mrd.ideal);
          tst_r  <= tst_r + WSUM_W'(mrd.stretch);
          tsh_r  <= tsh_r + WSUM_W'(mrd.shrink);
          npos_r <= npos_r + CNT_W'((mrd.ideal != '0) || (mrd.shrink != '0));
          tup_r  <= tup_r + CNT_W'(mrd.stretch != '0);
          tdn_r  <= tdn_r + CNT_W'(mrd.shrink != '0);
        end
      end
      ST_SETUP: begin
        grow_r  <= grow_c;
        ispos_r <= (grow_c[SIZE_W-1] && (tsh_r == '0)) ? npos_r : n_r;
        done_r  <= '0;
        idx_r   <= '0;
      end
      ST_PART_MUL: begin
        cur_id_r <= mrd.ideal;
        if (!grow_r[SIZE_W-1]) begin
          if (tst_r == '0) begin
            dvd_r <= grow_w;
            dvs_r <= WSUM_W'(n_r);
          end else begin
            dvd_r <= prod_st;
            dvs_r <= tst_r;
          end
        end else if (mrd.ideal == '0 && mrd.shrink == '0) begin
          dvd_r <= '0;
          dvs_r <= '0;
        end else if (tsh_r == '0) begin
          dvd_r <= grow_w;
          dvs_r <= WSUM_W'(ispos_r);
        end else begin
          dvd_r <= prod_sh;
          dvs_r <= tsh_r;
        end
      end
      ST_PART_WAIT: begin
        if (div_done) begin
          done_r <= done_r + SIZE_W'(quot);
          idx_r  <= idx_r + CNT_W'(1);
        end
      end
      ST_REM_SETUP: begin
        neg_r  <= 1'b0;
        idx_r  <= '0;
        up_r   <= !grow_r[SIZE_W-1];
        all_r  <= (!grow_r[SIZE_W-1] ? tup_r : tdn_r) != '0;
        grow_r <= g_c;
        done_r <= d_c;
        dvd_r  <= WIDE_W'(g_c - d_c + tk_s - SIZE_W'(1));
        dvs_r  <= WSUM_W'(tk_c);
      end
      ST_REM_WAIT: begin
        if (div_done) begin
          per_r <= SIZE_W'(quot);
        end
      end
      ST_REM_RD: begin
        jr_r <= j_c;
      end
      ST_REM_UPD: begin
        done_r <= d_new;
        idx_r  <= (!last_c && (d_new < grow_r)) ? idx_r + CNT_W'(1) : '0;
      end
      ST_CHECK: begin
        if (idx_r < n_r) begin
          idx_r  <= idx_r + CNT_W'(1);
          rvld_r <= 1'b1;
        end
        if (rvld_r && srd[SIZE_W-1]) begin
          neg_r <= 1'b1;
        end
        if (scan_end) begin
          idx_r <= '0;
        end
      end
      ST_EMIT_LD: begin
        out_size_r  <= (zero_r || srd[SIZE_W-1]) ? '0 : size_rdata[OSIZE_W-1:0];
        out_clamp_r <= !zero_r && srd[SIZE_W-1];
        out_last_r  <= last_c;
      end
      ST_EMIT_HOLD: begin
        if (out_acc) begin
          idx_r <= last_c ? '0 : idx_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (state_r == ST_REM_WAIT && div_done && !(done_r < grow_r)) begin
      idx_r <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_member_size = out_size_r;
  assign out_was_clamped = out_clamp_r;
  assign out_last_size   = out_last_r;

  a_out_only_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_EMIT_HOLD)
    else $error("result valid outside emit hold");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_MEMBERS))
    else $error("member count beyond capacity");

  a_close_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> (state_r == ST_LOAD && cnt_r == '0))
    else $error("group not closed after final result");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_PART_WAIT || state_r == ST_REM_WAIT))
    else $error("divider finished outside a wait state");

endmodule

[sim/tb_stretch_shrink_size_distributor_core.sv]
// Testbench of stretch_shrink_size_distributor_core: member groups in, sizes out.
// Predicts sizes with its own distributor model; depends on ssd_pkg and the RTL.
module tb_stretch_shrink_size_distributor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ssd_pkg::*;

  typedef struct {
    logic [OSIZE_W-1:0] msize;
    logic               clamped;
    logic               last;
  } size_t;

  typedef struct {
    int unsigned ideal;
    int unsigned stretch;
    int unsigned shrink;
    int          avail;
    bit          last;
    bit          typed;
    int unsigned exp_size;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [IDEAL_W-1:0] in_member_ideal = '0;
  logic [WGT_W-1:0] in_member_stretch = '0;
  logic [WGT_W-1:0] in_member_shrink = '0;
  logic signed [AVAIL_W-1:0] in_available_size = '0;
  logic in_last_member = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [OSIZE_W-1:0] out_member_size;
  logic out_was_clamped;
  logic out_last_size;

  size_t pending_sizes[$];
  longint grp_ideal[MAX_MEMBERS], grp_stretch[MAX_MEMBERS], grp_shrink[MAX_MEMBERS];
  int grp_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 0;

  always #2 clk = ~clk;

  stretch_shrink_size_distributor_core DUT (.*);

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return 0;
    return a / b;
  endfunction

  // one member transaction accepted: load it and, on the last one, queue the sizes
  function automatic void take_member(int unsigned ideal, int unsigned stretch,
                                      int unsigned shrink, int avail, bit last);
    longint id[MAX_MEMBERS], st[MAX_MEMBERS], sh[MAX_MEMBERS], sz[MAX_MEMBERS];
    longint tid, tst, tsh, grow, done, is_pos, part, takers, per, amt;
    bit ok, up, all;
    int n, passes, m, i, j;
    size_t r;
    if (grp_count < MAX_MEMBERS) begin
      grp_ideal[grp_count] = longint'(ideal);
      grp_stretch[grp_count] = longint'(stretch);
      grp_shrink[grp_count] = longint'(shrink);
      grp_count++;
    end
    if (!last) return;
    n = grp_count;
    for (i = 0; i < n; i++) begin
      id[i] = grp_ideal[i];
      st[i] = grp_stretch[i];
      sh[i] = grp_shrink[i];
      sz[i] = 0;
    end
    ok = (avail <= 0);
    passes = n;
    while (!ok && passes > 0) begin
      passes--;
      tid = 0; tst = 0; tsh = 0;
      for (i = 0; i < n; i++) begin
        tid += id[i]; tst += st[i]; tsh += sh[i];
      end
      grow = longint'(avail) - tid;
      is_pos = longint'(n);
      if (grow < 0 && tsh == 0) begin
        is_pos = 0;
        for (i = 0; i < n; i++) if (id[i] > 0 || sh[i] > 0) is_pos++;
      end
      done = 0;
      for (i = 0; i < n; i++) begin
        if (grow >= 0) part = (tst == 0) ? qdiv(grow, longint'(n)) : qdiv(grow * st[i], tst);
        else if (id[i] == 0 && sh[i] == 0) part = 0;
        else part = (tsh == 0) ? qdiv(grow, is_pos) : qdiv(grow * sh[i], tsh);
        sz[i] = id[i] + part;
        done += part;
      end
      if (grow != done) begin
        up = grow > 0;
        if (grow < 0) begin
          grow = -grow; done = -done;
        end
        takers = 0;
        for (i = 0; i < n; i++) if ((up ? st[i] : sh[i]) > 0) takers++;
        all = (takers != 0);
        if (takers == 0) takers = is_pos;
        per = qdiv(grow - done + takers - 1, takers);
        m = n;
        i = 0;
        while (done < grow && m > 0) begin
          j = (i % 2) ? i : n - i - 1;
          m--;
          if (j >= 0 && j < n && (all || (up ? st[j] : sh[j]) > 0)) begin
            amt = (grow - done < per) ? grow - done : per;
            if (!up && amt > sz[j]) amt = sz[j];
            sz[j] += up ? amt : -amt;
            done += amt;
          end
          i++;
        end
      end
      ok = 1;
      for (i = 0; i < n; i++) if (sz[i] < 0) begin
        id[i] = 0; sh[i] = 0; ok = 0;
      end
    end
    for (i = 0; i < n; i++) begin
      r.clamped = sz[i] < 0;
      r.msize = r.clamped ? '0 : OSIZE_W'(sz[i]);
      r.last = (i == n - 1);
      pending_sizes.push_back(r);
    end
    grp_count = 0;
  endfunction

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    size_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sizes.size() == 0) begin
        $error("unexpected size transaction: %0d", out_member_size);
        failed = 1;
      end else begin
        e = pending_sizes.pop_front();
        if (out_member_size !== e.msize) begin
          $error("member_size exp %0d got %0d", e.msize, out_member_size);
          failed = 1;
        end
        if (out_was_clamped !== e.clamped) begin
          $error("was_clamped exp %0d got %0d", e.clamped, out_was_clamped);
          failed = 1;
        end
        if (out_last_size !== e.last) begin
          $error("last_size exp %0d got %0d", e.last, out_last_size);
          failed = 1;
        end
      end
    end
  end

  task automatic send_member(row_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_member_ideal <= IDEAL_W'(r.ideal);
    in_member_stretch <= WGT_W'(r.stretch);
    in_member_shrink <= WGT_W'(r.shrink);
    in_available_size <= AVAIL_W'(r.avail);
    in_last_member <= r.last;
    do @(posedge clk); while (in_stall);
    take_member(r.ideal, r.stretch, r.shrink, r.avail, r.last);
    if (r.typed) begin
      pending_sizes[$].msize = OSIZE_W'(r.exp_size);
      pending_sizes[$].clamped = 0;
    end
  endtask

  row_t directed[] = '{
    '{100, 5, 5, 0, 1, 1, 0},
    '{65535, 1023, 1023, -32768, 1, 1, 0},
    '{0, 0, 0, 32767, 1, 1, 32767},
    '{65535, 0, 1023, 32767, 1, 1, 32767},
    '{65535, 0, 0, 1, 1, 1, 1},
    '{10, 1, 0, 0, 0, 0, 0},
    '{20, 2, 0, 0, 0, 0, 0},
    '{30, 4, 0, 100, 1, 0, 0},
    '{10, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0},
    '{10, 0, 0, 0, 0, 0, 0},
    '{7, 0, 0, 11, 1, 0, 0},
    '{0, 0, 1023, 0, 0, 0, 0},
    '{1000, 0, 1, 500, 1, 0, 0},
    '{5, 0, 0, 0, 0, 0, 0},
    '{5, 0, 0, 0, 0, 0, 0},
    '{5, 0, 0, 32767, 1, 0, 0},
    '{40000, 3, 7, 0, 0, 0, 0},
    '{30000, 1023, 0, -1, 0, 0, 0},
    '{50, 0, 1023, 1000, 1, 0, 0}
  };

  initial begin
    row_t r;
    int nitems, gsize, total, k, av;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[d]) send_member(directed[d]);
    nitems = 0;
    while (nitems < 450) begin
      if (nitems < 150) begin
        send_gap_pct = 29; recv_stall_pct = 59;
      end else if (nitems < 300) begin
        send_gap_pct = 59; recv_stall_pct = 29;
      end else begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
      case ($urandom_range(19))
        0: gsize = $urandom_range(33, 36);
        1, 2: gsize = $urandom_range(20, 32);
        default: gsize = $urandom_range(1, 8);
      endcase
      total = 0;
      for (k = 0; k < gsize; k++) begin
        r.ideal = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(3000);
        r.stretch = ($urandom_range(3) == 0) ? 0 : $urandom_range(1023);
        r.shrink = ($urandom_range(3) == 0) ? 0 : $urandom_range(1023);
        if ($urandom_range(4) == 0) begin
          r.stretch = 0; r.shrink = 0;
        end
        if (k < MAX_MEMBERS) total += r.ideal;
        r.last = (k == gsize - 1);
        r.typed = 0;
        r.exp_size = 0;
        if (r.last && $urandom_range(3) != 0)
          av = total + $signed($urandom_range(4000)) - 2000;
        else
          av = $signed($urandom_range(65535)) - 32768;
        if (av > 32767) av = 32767;
        if (av < -32768) av = -32768;
        r.avail = av;
        send_member(r);
        nitems++;
      end
    end
    in_valid <= 0;
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && pending_sizes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
design/ssd_pkg.sv
design/ssd_ram.sv
design/ssd_div.sv
design/stretch_shrink_size_distributor_core.sv
sim/tb_stretch_shrink_size_distributor_core.sv
